>>> design/sur_pkg.sv
// Package for the sound unit register file: sizes, offset map, command codes,
// the decoded access struct and the address decoder.
// No dependencies.
package sur_pkg;

    // Sizing
    localparam int VOICE_COUNT = 24;
    localparam int RAM_BYTES   = 524288;   // must be a power of two
    localparam int RAM_HALVES  = RAM_BYTES / 2;
    localparam int PTR_W       = $clog2(RAM_BYTES);
    localparam int RAM_AW      = PTR_W - 1;
    localparam int VOICE_REGS  = VOICE_COUNT * 8;
    localparam int VOICE_AW    = $clog2(VOICE_REGS);
    localparam int FLAG_SETS   = 6;
    localparam int FLAG_SET_W  = $clog2(FLAG_SETS);
    localparam int CTRL_REGS   = 32;
    localparam int CTRL_AW     = $clog2(CTRL_REGS);
    localparam int DATA_W      = 16;
    localparam int OFF_W       = 10;
    localparam int CMD_W       = 2;

    // Offset map
    localparam logic [OFF_W-1:0] OFF_CTRL_BASE    = 10'h180;
    localparam logic [OFF_W-1:0] OFF_CTRL_LO_END  = 10'h186;
    localparam logic [OFF_W-1:0] OFF_FLAG_BASE    = 10'h188;
    localparam logic [OFF_W-1:0] OFF_FLAG_END     = 10'h1A0;
    localparam logic [OFF_W-1:0] OFF_CTRL_HI_BASE = 10'h1A2;
    localparam logic [OFF_W-1:0] OFF_XFER_ADDR    = 10'h1A6;
    localparam logic [OFF_W-1:0] OFF_FIFO         = 10'h1A8;
    localparam logic [OFF_W-1:0] OFF_STATUS       = 10'h1AE;
    localparam logic [OFF_W-1:0] OFF_CTRL_HI_END  = 10'h1BA;

    typedef enum logic [CMD_W-1:0] {
        CMD_REG_READ  = 2'd0,
        CMD_REG_WRITE = 2'd1,
        CMD_XFER_READ = 2'd2,
        CMD_NONE      = 2'd3
    } t_command;

    // Where a read result comes from
    typedef enum logic [1:0] {
        SRC_DIRECT,
        SRC_VOICE,
        SRC_RAM
    } t_source;

    typedef struct packed {
        logic                  voice_wr;
        logic                  voice_rd;
        logic [VOICE_AW-1:0]   voice_idx;
        logic                  ctrl_wr;
        logic                  ctrl_rd;
        logic [CTRL_AW-1:0]    ctrl_idx;
        logic                  flag_wr;
        logic                  flag_rd;
        logic [FLAG_SET_W-1:0] flag_set;
        logic                  flag_high;
        logic                  fifo_wr;
        logic                  xfer_rd;
        logic                  xfer_addr_wr;
    } t_access;

    // Decode one request into enables and indexes
    function automatic t_access decode_access(input logic [CMD_W-1:0] cmd,
                                              input logic [OFF_W-1:0] off);
        t_access          acc;
        logic             is_rd;
        logic             is_wr;
        logic             even;
        logic             voice_hit;
        logic             flag_hit;
        logic             ctrl_ok;
        logic [OFF_W-1:0] flag_rel;
        acc       = '0;
        is_rd     = (t_command'(cmd) == CMD_REG_READ);
        is_wr     = (t_command'(cmd) == CMD_REG_WRITE);
        even      = !off[0];
        voice_hit = (off < OFF_CTRL_BASE) && even && (off[9:4] < 6'(VOICE_COUNT));
        flag_hit  = (off >= OFF_FLAG_BASE) && (off < OFF_FLAG_END) && even;
        ctrl_ok   = even && (((off >= OFF_CTRL_BASE) && (off <= OFF_CTRL_LO_END)) ||
                             ((off >= OFF_CTRL_HI_BASE) && (off <= OFF_CTRL_HI_END)));
        flag_rel  = off - OFF_FLAG_BASE;

        acc.voice_idx    = VOICE_AW'(off[8:1]);
        acc.voice_wr     = is_wr && voice_hit;
        acc.voice_rd     = is_rd && voice_hit;
        acc.ctrl_idx     = off[5:1];
        acc.ctrl_rd      = is_rd && ctrl_ok;
        acc.ctrl_wr      = is_wr && ctrl_ok && (off != OFF_FIFO) && (off != OFF_STATUS);
        acc.flag_set     = FLAG_SET_W'(flag_rel[4:2]);
        acc.flag_high    = off[1];
        acc.flag_wr      = is_wr && flag_hit;
        acc.flag_rd      = is_rd && flag_hit;
        acc.fifo_wr      = is_wr && (off == OFF_FIFO);
        acc.xfer_addr_wr = is_wr && (off == OFF_XFER_ADDR);
        acc.xfer_rd      = (t_command'(cmd) == CMD_XFER_READ);
        return acc;
    endfunction

endpackage

>>> design/sur_voice_ram.sv
// Voice register store: VOICE_COUNT x 8 halfwords with a valid bit per entry.
// Depends on sur_pkg.
module sur_voice_ram (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sur_pkg::t_access       i_acc,
    input  logic [15:0]            i_wdata,
    output logic [15:0]            o_rd_data
);
    import sur_pkg::*;

    logic [DATA_W-1:0]     r_mem [VOICE_REGS];
    logic [VOICE_REGS-1:0] r_valid;
    logic [DATA_W-1:0]     r_rd_data;
    logic                  r_rd_valid;

    // Write and read the store; read data is registered
    always_ff @(posedge i_clk) begin
        if (i_acc.voice_wr) begin
            r_mem[i_acc.voice_idx] <= i_wdata;
        end
        if (i_acc.voice_rd) begin
            r_rd_data <= r_mem[i_acc.voice_idx];
        end
    end

    // Track written entries; an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_acc.voice_wr) begin
                r_valid[i_acc.voice_idx] <= 1'b1;
            end
            if (i_acc.voice_rd) begin
                r_rd_valid <= r_valid[i_acc.voice_idx];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

>>> design/sur_sample_ram.sv
// Sample RAM with transfer pointer and clearing pass after reset.
// Depends on sur_pkg.
module sur_sample_ram (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sur_pkg::t_access       i_acc,
    input  logic [15:0]            i_wdata,
    output logic [15:0]            o_rd_data,
    output logic                   o_clearing
);
    import sur_pkg::*;

    logic [DATA_W-1:0] r_mem [RAM_HALVES];
    logic [PTR_W-1:0]  r_ptr;
    logic [PTR_W-1:0]  n_ptr;
    logic [RAM_AW-1:0] r_clr_idx;
    logic              r_clearing;
    logic [DATA_W-1:0] r_rd_data;
    logic [RAM_AW-1:0] ptr_idx;

    assign ptr_idx = r_ptr[PTR_W-1:1];

    // Next pointer: load from the transfer address, advance by two and wrap
    always_comb begin
        n_ptr = r_ptr;
        if (i_acc.xfer_addr_wr) begin
            n_ptr = PTR_W'({i_wdata, 3'b000});
        end else if (i_acc.fifo_wr || i_acc.xfer_rd) begin
            n_ptr = r_ptr + PTR_W'(2);
        end
    end

    // Hold pointer and clearing sweep state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_clr_idx  <= '0;
            r_clearing <= 1'b1;
        end else begin
            r_ptr <= n_ptr;
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + RAM_AW'(1);
                if (r_clr_idx == RAM_AW'(RAM_HALVES - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    // Memory port: clear sweep or FIFO write, registered transfer read
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_acc.fifo_wr) begin
            r_mem[ptr_idx] <= i_wdata;
        end
        if (i_acc.xfer_rd) begin
            r_rd_data <= r_mem[ptr_idx];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

>>> design/sur_ctrl_regs.sv
// Plain control halfwords and the six per-voice flag sets.
// Depends on sur_pkg.
module sur_ctrl_regs (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sur_pkg::t_access       i_acc,
    input  logic [15:0]            i_wdata,
    output logic [15:0]            o_rd_data
);
    import sur_pkg::*;

    logic [DATA_W-1:0]      r_ctrl  [CTRL_REGS];
    logic [VOICE_COUNT-1:0] r_flags [FLAG_SETS];
    logic [31:0]            wr_bits;
    logic [31:0]            flag_word;
    logic                   set_ok;

    assign set_ok    = (i_acc.flag_set < FLAG_SET_W'(FLAG_SETS - 1)) ||
                       (i_acc.flag_set == FLAG_SET_W'(FLAG_SETS - 1));
    assign wr_bits   = i_acc.flag_high ? {i_wdata, 16'h0000} : {16'h0000, i_wdata};
    assign flag_word = set_ok ? 32'(r_flags[i_acc.flag_set]) : '0;

    // Update control halfwords; flag writes only set bits, those past the last voice drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CTRL_REGS; i++) begin
                r_ctrl[i] <= '0;
            end
            for (int k = 0; k < FLAG_SETS; k++) begin
                r_flags[k] <= '0;
            end
        end else begin
            if (i_acc.ctrl_wr) begin
                r_ctrl[i_acc.ctrl_idx] <= i_wdata;
            end
            if (i_acc.flag_wr && set_ok) begin
                r_flags[i_acc.flag_set] <= r_flags[i_acc.flag_set] |
                                           VOICE_COUNT'(wr_bits);
            end
        end
    end

    // Select the read halfword; unmapped addresses read zero
    always_comb begin
        o_rd_data = '0;
        if (i_acc.ctrl_rd) begin
            o_rd_data = r_ctrl[i_acc.ctrl_idx];
        end else if (i_acc.flag_rd) begin
            o_rd_data = i_acc.flag_high ? flag_word[31:16] : flag_word[15:0];
        end
    end

endmodule

>>> design/sound_unit_register_file_top.sv
// A read result passes the pending stage (r_s1_*) and the result register, then shows on o_strobe.
// Throughput: one request per cycle while busy is low; all state updates commit at the accepting edge.
// Reset: synchronous; afterwards busy stays high while the sample RAM clearing sweep
// runs over all RAM_HALVES (262144) halfwords, one halfword per cycle.
// The receiver cannot stall: every result is shown for exactly one cycle.
// Depends on sur_pkg, sur_voice_ram, sur_sample_ram and sur_ctrl_regs.
module sound_unit_register_file_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [9:0]  i_offset,
    input  logic [15:0] i_write_data,
    output logic        o_strobe,
    output logic [15:0] o_read_data
);
    import sur_pkg::*;

    logic              accept;
    logic              clearing;
    logic              read_req;
    t_access           dec;
    t_access           acc;
    t_source           src;
    logic [DATA_W-1:0] voice_data;
    logic [DATA_W-1:0] ram_data;
    logic [DATA_W-1:0] direct_data;
    logic              r_s1_valid;
    t_source           r_s1_src;
    logic [DATA_W-1:0] r_s1_direct;
    logic              r_strobe;
    logic [DATA_W-1:0] r_read_data;
    logic [DATA_W-1:0] n_read_data;

    // Decode and gate the request
    assign accept   = start && !clearing;
    assign dec      = decode_access(i_command, i_offset);
    assign acc      = accept ? dec : '0;
    assign read_req = accept && ((t_command'(i_command) == CMD_REG_READ) ||
                                 (t_command'(i_command) == CMD_XFER_READ));
    assign src      = acc.xfer_rd ? SRC_RAM : (acc.voice_rd ? SRC_VOICE : SRC_DIRECT);

    sur_voice_ram u_voice (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_wdata   (i_write_data),
        .o_rd_data (voice_data)
    );

    sur_sample_ram u_sample (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_wdata    (i_write_data),
        .o_rd_data  (ram_data),
        .o_clearing (clearing)
    );

    sur_ctrl_regs u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_wdata   (i_write_data),
        .o_rd_data (direct_data)
    );

    // Register the pending read and its source
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_src   <= SRC_DIRECT;
        end else begin
            r_s1_valid <= read_req;
            r_s1_src   <= src;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_direct <= direct_data;
    end

    // Pick the result halfword
    always_comb begin
        unique case (r_s1_src)
            SRC_VOICE: n_read_data = voice_data;
            SRC_RAM:   n_read_data = ram_data;
            default:   n_read_data = r_s1_direct;
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_read_data <= n_read_data;
    end

    assign busy        = clearing;
    assign o_strobe    = r_strobe;
    assign o_read_data = r_read_data;

endmodule

>>> design/sur_checker.sv
// Port-level checks for the sound unit register file, bound to the top level.
// Depends on sur_pkg and sound_unit_register_file_top.
module sur_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_command,
    input logic       o_strobe
);
    import sur_pkg::*;

    logic read_acc;

    assign read_acc = start && !busy &&
                      ((i_command == CMD_REG_READ) || (i_command == CMD_XFER_READ));

    // Reset starts the clearing sweep
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy not raised after reset");

    // No result while the clearing sweep runs
    a_no_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_strobe)
        else $error("result shown during clearing sweep");

    // Every accepted read request gives a result on o_strobe
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        read_acc |-> ##2 o_strobe)
        else $error("read request lost");

    // Every result comes from an earlier accepted read request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(read_acc, 2))
        else $error("result without read request");

endmodule

bind sound_unit_register_file_top sur_checker u_sur_checker (.*);
